[rtl/fir_pkg.sv]
package fir_pkg;

  localparam int DATA_W      = 16;
  localparam int IDX_W       = 10;
  localparam int SHIFT_W     = 5;
  localparam int SAMPLE_BITS = 16;
  localparam int FIR_TAPS    = 1024;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(15);

  // action codes
  localparam logic ACT_TAP  = 1'b0;
  localparam logic ACT_PUSH = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [IDX_W-1:0]         tap_index;
    logic signed [DATA_W-1:0] tap_value;
    logic signed [DATA_W-1:0] sample_value;
  } fir_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] filtered_sample;
    logic                     saturated;
  } fir_out_t;

  typedef struct packed {
    logic                     shift_in;
    logic                     rotate;
    logic                     wr;
    logic [IDX_W-1:0]         wr_index;
    logic signed [DATA_W-1:0] wr_value;
  } fir_ctl_t;

endpackage

[rtl/fir_cell.sv]
module fir_cell import fir_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  fir_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] prev_x,
  input  logic signed [DATA_W-1:0] next_x,
  input  logic signed [DATA_W-1:0] next_h,
  output logic signed [DATA_W-1:0] x,
  output logic signed [DATA_W-1:0] h
);

  logic hit;

  assign hit = ctl.wr && (32'(ctl.wr_index) == IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      x <= '0;
      h <= '0;
    end else begin
      if (ctl.shift_in) begin
        x <= prev_x;
      end else if (ctl.rotate) begin
        x <= next_x;
      end
      if (ctl.rotate) begin
        h <= next_h;
      end else if (hit) begin
        h <= ctl.wr_value;
      end
    end
  end

endmodule

[rtl/fir_mac.sv]
module fir_mac import fir_pkg::*; #(
  parameter int TAPS = FIR_TAPS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     mac_en,
  input  logic                     round_en,
  input  logic signed [DATA_W-1:0] x,
  input  logic signed [DATA_W-1:0] h,
  input  logic [SHIFT_W-1:0]       shift,
  output fir_out_t                 res
);

  localparam int ACC_W = 2 * DATA_W + $clog2(TAPS) + 1;
  localparam int SUM_W = ((ACC_W > 32) ? ACC_W : 32) + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO =
    SUM_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  logic signed [2*DATA_W-1:0] prod;
  logic                       prod_v;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SUM_W-1:0]    rnd;
  logic [SUM_W-1:0]           half;
  logic signed [SUM_W-1:0]    shifted;
  logic signed [SUM_W-1:0]    clipped;
  logic                       clip;

  // half of one output lsb, zero when no shift
  assign half = ({{(SUM_W-1){1'b0}}, 1'b1} << shift) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= mac_en;
    end
    if (mac_en) begin
      prod <= x * h;
    end
    if (clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
    if (round_en) begin
      rnd <= SUM_W'(acc) + $signed(half);
    end
  end

  assign shifted = rnd >>> shift;

  always_comb begin
    clipped = shifted;
    clip    = 1'b0;
    if (shifted > SAT_HI) begin
      clipped = SAT_HI;
      clip    = 1'b1;
    end else if (shifted < SAT_LO) begin
      clipped = SAT_LO;
      clip    = 1'b1;
    end
    res.filtered_sample = clipped[DATA_W-1:0];
    res.saturated       = clip;
  end

endmodule

[rtl/fir_filter_direct_form.sv]
// channel  direction  handshake                 payload
// item     in         item_valid / item_stall   fir_in_t (tap write or sample push)
// result   out        result_valid / result_stall  fir_out_t
// shift    in         shift_wr_en               shift_wr_data
//
// a sample push rotates the tap ring once past a single
// multiply-accumulate unit at cell 0, then drain, round and saturate
// a tap write leaves the sequencer idle; items are taken only while the sequencer is idle
// synchronous reset clears delay line, taps, sequencer and output valid
// a finished result waits in the output register while the next transaction is taken
// while that register is still full and result_stall is high, a new result holds the sequencer in finish
module fir_filter_direct_form import fir_pkg::*; #(
  parameter int TAPS = FIR_TAPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  fir_in_t            item,
  output logic               result_valid,
  input  logic               result_stall,
  output fir_out_t           result,
  input  logic               shift_wr_en,
  input  logic [SHIFT_W-1:0] shift_wr_data
);

  localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_FINISH
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     cnt;
  logic [SHIFT_W-1:0]   output_shift;
  logic                 accept;
  logic                 push;
  fir_ctl_t             ctl;
  fir_out_t             res;

  logic signed [DATA_W-1:0] x_ring [TAPS];
  logic signed [DATA_W-1:0] h_ring [TAPS];
  logic signed [DATA_W-1:0] prev_x [TAPS];

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign push       = accept && (item.action == ACT_PUSH);

  always_comb begin
    ctl.shift_in = push;
    ctl.rotate   = (state == ST_RUN);
    ctl.wr       = accept && (item.action == ACT_TAP);
    ctl.wr_index = item.tap_index;
    ctl.wr_value = item.tap_value;
  end

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign prev_x[k] = item.sample_value;
    end else begin : g_body
      assign prev_x[k] = x_ring[k-1];
    end

    fir_cell #(
      .IDX(k)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .prev_x(prev_x[k]),
      .next_x(x_ring[(k + 1) % TAPS]),
      .next_h(h_ring[(k + 1) % TAPS]),
      .x     (x_ring[k]),
      .h     (h_ring[k])
    );
  end

  fir_mac #(
    .TAPS(TAPS)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .clear   (push),
    .mac_en  (state == ST_RUN),
    .round_en(state == ST_ROUND),
    .x       (x_ring[0]),
    .h       (h_ring[0]),
    .shift   (output_shift),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
      output_shift <= SHIFT_RESET;
    end else begin
      if (shift_wr_en) begin
        output_shift <= shift_wr_data;
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (push) begin
            state <= ST_RUN;
            cnt   <= '0;
          end
        end
        ST_RUN: begin
          if (cnt == CNT_LAST) begin
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!result_valid || !result_stall) begin
            result       <= res;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_push_starts_run: assert property (@(posedge clk) disable iff (rst)
    push |=> (state == ST_RUN) && (cnt == '0))
    else $error("sample push did not start a ring pass");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.action == ACT_TAP)) |=> (state == ST_IDLE))
    else $error("tap write left idle");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && (cnt == CNT_LAST) |=> (state == ST_DRAIN))
    else $error("ring pass did not end after last tap");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ST_FINISH))
    else $error("result appeared outside finish");
`endif

endmodule

[bench/tb_fir_filter_direct_form.sv]
module tb_fir_filter_direct_form;
  import fir_pkg::*;

  localparam int TAP_COUNT = FIR_TAPS;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 290;
  localparam int HOLD_CYCLES = 4 * TAP_COUNT;
  localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;
  localparam longint SAT_HI = longint'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef enum logic [1:0] {ROW_TAP, ROW_PUSH, ROW_SHIFT} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
    logic              typed;
    fir_out_t          want;
  } stim_row_t;

  localparam fir_out_t ANY_OUT = '0;
  localparam int PLAN_LEN = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  fir_in_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  fir_out_t result;
  logic shift_wr_en = 1'b0;
  logic [SHIFT_W-1:0] shift_wr_data = '0;

  logic signed [DATA_W-1:0] coef [TAP_COUNT];
  logic signed [DATA_W-1:0] ring [TAP_COUNT];
  int unsigned ring_head;
  logic [SHIFT_W-1:0] shift_cfg;

  fir_out_t outputs_due [$];
  int unsigned mismatches = 0;
  longint unsigned cycle_count = 0;
  bit hold_wanted = 1'b0;

  stim_row_t plan [PLAN_LEN] = '{
    '{ROW_PUSH,  10'd0,    16'h1234, 1'b1, '{16'sh0000, 1'b0}},
    '{ROW_TAP,   10'd0,    16'h7FFF, 1'b0, ANY_OUT},
    '{ROW_PUSH,  10'd0,    16'h0000, 1'b1, '{16'sh0000, 1'b0}},
    '{ROW_PUSH,  10'd0,    16'h7FFF, 1'b0, ANY_OUT},
    '{ROW_TAP,   10'd0,    16'h8000, 1'b0, ANY_OUT},
    '{ROW_PUSH,  10'd0,    16'h8000, 1'b1, '{16'sh7FFF, 1'b1}},
    '{ROW_PUSH,  10'd0,    16'h7FFF, 1'b0, ANY_OUT},
    '{ROW_TAP,   10'd1023, 16'h7FFF, 1'b0, ANY_OUT},
    '{ROW_TAP,   10'd0,    16'h0000, 1'b0, ANY_OUT},
    '{ROW_PUSH,  10'd0,    16'h0000, 1'b1, '{16'sh0000, 1'b0}},
    '{ROW_SHIFT, 10'd0,    16'd0,    1'b0, ANY_OUT},
    '{ROW_TAP,   10'd0,    16'h0001, 1'b0, ANY_OUT},
    '{ROW_PUSH,  10'd0,    16'h0005, 1'b0, ANY_OUT},
    '{ROW_TAP,   10'd1,    16'h7FFF, 1'b0, ANY_OUT},
    '{ROW_PUSH,  10'd0,    16'h7FFF, 1'b1, '{16'sh7FFF, 1'b1}},
    '{ROW_PUSH,  10'd0,    16'h8000, 1'b0, ANY_OUT},
    '{ROW_SHIFT, 10'd0,    16'd31,   1'b0, ANY_OUT},
    '{ROW_PUSH,  10'd0,    16'h8000, 1'b0, ANY_OUT},
    '{ROW_SHIFT, 10'd0,    16'd1,    1'b0, ANY_OUT},
    '{ROW_TAP,   10'd1,    16'h8000, 1'b0, ANY_OUT},
    '{ROW_PUSH,  10'd0,    16'h7FFF, 1'b0, ANY_OUT},
    '{ROW_PUSH,  10'd0,    16'h0000, 1'b1, '{16'sh8000, 1'b1}},
    '{ROW_PUSH,  10'd0,    16'h0003, 1'b0, ANY_OUT},
    '{ROW_SHIFT, 10'd0,    16'd15,   1'b0, ANY_OUT}
  };

  logic [SHIFT_W-1:0] phase_shift [PHASES] = '{5'd15, 5'd0, 5'd31, 5'd8, 5'd20, 5'd15};

  fir_filter_direct_form #(.TAPS(TAP_COUNT)) dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .shift_wr_en   (shift_wr_en),
    .shift_wr_data (shift_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic fir_out_t convolve_push(input logic signed [DATA_W-1:0] x);
    longint acc;
    longint y;
    int unsigned pos;
    int k;
    fir_out_t r;
    acc = 0;
    ring_head = (ring_head + 1) % TAP_COUNT;
    ring[ring_head] = x;
    pos = ring_head;
    for (k = 0; k < TAP_COUNT; k++) begin
      acc += longint'(coef[k]) * longint'(ring[pos]);
      pos = (pos == 0) ? TAP_COUNT - 1 : pos - 1;
    end
    if (shift_cfg == 0) begin
      y = acc;
    end else begin
      y = (acc + (longint'(1) << (int'(shift_cfg) - 1))) >>> int'(shift_cfg);
    end
    r.saturated = 1'b0;
    if (y > SAT_HI) begin
      y = SAT_HI;
      r.saturated = 1'b1;
    end else if (y < SAT_LO) begin
      y = SAT_LO;
      r.saturated = 1'b1;
    end
    r.filtered_sample = y[DATA_W-1:0];
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1: return '0;
      2, 3: return DATA_W'($urandom_range(0, 511) - 256);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic fir_in_t random_item();
    fir_in_t it;
    it.action = ($urandom_range(0, 1) == 0) ? ACT_TAP : ACT_PUSH;
    it.tap_index = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 31))
                                               : IDX_W'($urandom);
    it.tap_value = random_word();
    it.sample_value = random_word();
    return it;
  endfunction

  task automatic send_item(input fir_in_t it, input logic given, input fir_out_t given_out);
    fir_out_t predicted;
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    if (it.action == ACT_TAP) begin
      if (it.tap_index < TAP_COUNT) coef[it.tap_index] = it.tap_value;
    end else begin
      predicted = convolve_push(it.sample_value);
      outputs_due.push_back(given ? given_out : predicted);
    end
  endtask

  task automatic wait_quiet(input int pause);
    item_valid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (pause) @(posedge clk);
  endtask

  task automatic write_output_shift(input logic [SHIFT_W-1:0] v);
    shift_wr_en <= 1'b1;
    shift_wr_data <= v;
    @(posedge clk);
    shift_wr_en <= 1'b0;
    shift_cfg = v;
  endtask

  // result side: random stall segments, one long hold when asked
  initial begin : result_side
    int seg_len;
    int stall_pct;
    @(posedge clk);
    forever begin
      if (hold_wanted) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_wanted = 1'b0;
      end
      seg_len = $urandom_range(5, 60);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 95;
      endcase
      repeat (seg_len) begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    fir_out_t due;
    if (!rst && result_valid && !result_stall) begin
      if (outputs_due.size() == 0) begin
        $display("%0t: unexpected transaction: filtered_sample %0d saturated %0b",
                 $time, result.filtered_sample, result.saturated);
        mismatches++;
      end else begin
        due = outputs_due.pop_front();
        if (result.filtered_sample !== due.filtered_sample) begin
          $display("%0t: filtered_sample expected %0d actual %0d",
                   $time, due.filtered_sample, result.filtered_sample);
          mismatches++;
        end
        if (result.saturated !== due.saturated) begin
          $display("%0t: saturated expected %0b actual %0b",
                   $time, due.saturated, result.saturated);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    fir_in_t it;
    int n;
    int burst;
    int gap_pct;
    foreach (coef[i]) coef[i] = '0;
    foreach (ring[i]) ring[i] = '0;
    ring_head = 0;
    shift_cfg = SHIFT_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SHIFT) begin
        wait_quiet(16);
        write_output_shift(plan[i].value[SHIFT_W-1:0]);
      end else begin
        it = random_item();
        if (plan[i].kind == ROW_TAP) begin
          it.action = ACT_TAP;
          it.tap_index = plan[i].idx;
          it.tap_value = plan[i].value;
        end else begin
          it.action = ACT_PUSH;
          it.sample_value = plan[i].value;
        end
        send_item(it, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_quiet(16);
      write_output_shift((p == 3 || p == 4) ? SHIFT_W'($urandom_range(1, 30)) : phase_shift[p]);
      gap_pct = (p == 2) ? 0 : 65;
      n = 0;
      while (n < PHASE_ITEMS) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          if (p == 1 && n == 100) hold_wanted = 1'b1;
          send_item(random_item(), 1'b0, ANY_OUT);
          n++;
        end
        if ($urandom_range(0, 99) < gap_pct) begin
          item_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end

    wait_quiet(TAP_COUNT + 8);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
